>>> rtl/damped_spring_impulse_macros.svh
// Assertion helpers for the spring impulse RTL
`ifndef DAMPED_SPRING_IMPULSE_MACROS_SVH
`define DAMPED_SPRING_IMPULSE_MACROS_SVH

// Same-cycle implication, off while reset is high
`define DSI_ASSERT_IMPLY(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("spring impulse check failed");

// Next-cycle implication, off while reset is high
`define DSI_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("spring impulse sequence check failed");

`endif

>>> rtl/dsi_pkg.sv
package dsi_pkg;

  localparam int WordW   = 32;
  localparam int CfgW    = 31;
  localparam int CfgIdxW = 2;
  localparam int DtW     = 17;
  localparam int QFrac   = 16;
  localparam int RootW   = 33;            // root and |d| components
  localparam int VelW    = 33;            // selected velocity magnitude
  localparam int SumW    = 2 * RootW;     // dx^2 + dy^2
  localparam int QuotW   = 17;            // |d|/len in Q16.16, at most 1.0

  localparam logic [CfgW-1:0] RestLenRst = 31'd65536;
  localparam logic [CfgW-1:0] StiffRst   = 31'd65536;
  localparam logic [CfgW-1:0] DampRst    = 31'd0;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_REST  = 2'd0,
    CFG_STIFF = 2'd1,
    CFG_DAMP  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic signed [WordW-1:0] first_pos_x;
    logic signed [WordW-1:0] first_pos_y;
    logic signed [WordW-1:0] second_pos_x;
    logic signed [WordW-1:0] second_pos_y;
    logic signed [WordW-1:0] first_vel_x;
    logic signed [WordW-1:0] first_vel_y;
    logic signed [WordW-1:0] second_vel_x;
    logic signed [WordW-1:0] second_vel_y;
    logic                    first_fixed;
    logic                    second_fixed;
    logic [DtW-1:0]          time_step;
  } in_t;

  typedef struct packed {
    logic signed [WordW-1:0] first_imp_x;
    logic signed [WordW-1:0] first_imp_y;
    logic signed [WordW-1:0] second_imp_x;
    logic signed [WordW-1:0] second_imp_y;
    logic                    apply_first;
    logic                    apply_second;
    logic                    coincident;
    logic                    saturated;
  } out_t;

  // Side data that rides along the root and divide pipelines; lane 0 = x, lane 1 = y
  typedef struct packed {
    logic [1:0][VelW-1:0] vmag;
    logic [1:0]           vneg;
    logic [1:0]           dneg;
    logic                 first_fixed;
    logic                 second_fixed;
    logic                 coincident;
    logic [DtW-1:0]       time_step;
  } carry_t;

endpackage

>>> rtl/dsi_sqrt.sv
module dsi_sqrt
  import dsi_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   valid_in,
  input  carry_t                 carry_in,
  input  logic [1:0][RootW-1:0]  amag_in,
  input  logic [SumW-1:0]        sum_in,
  output logic                   valid_out,
  output carry_t                 carry_out,
  output logic [1:0][RootW-1:0]  amag_out,
  output logic [RootW-1:0]       root_out
);

  localparam int RemW = SumW + 1;

  logic                  vld  [0:RootW];
  carry_t                cr   [0:RootW];
  logic [1:0][RootW-1:0] amag [0:RootW];
  logic [RootW-1:0]      root [0:RootW];
  logic [RemW-1:0]       rem  [0:RootW];

  assign vld[0]  = valid_in;
  assign cr[0]   = carry_in;
  assign amag[0] = amag_in;
  assign root[0] = '0;
  assign rem[0]  = RemW'(sum_in);

  // One root bit per stage, most significant first
  for (genvar i = 0; i < RootW; i++) begin : g_stage
    localparam int B = RootW - 1 - i;
    logic [RemW-1:0] trial;

    assign trial = (RemW'(root[i]) << (B + 1)) + (RemW'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      cr[i+1]   <= cr[i];
      amag[i+1] <= amag[i];
      if (rem[i] >= trial) begin
        rem[i+1]  <= rem[i] - trial;
        root[i+1] <= root[i] | (RootW'(1) << B);
      end else begin
        rem[i+1]  <= rem[i];
        root[i+1] <= root[i];
      end
    end
  end

  assign valid_out = vld[RootW];
  assign carry_out = cr[RootW];
  assign amag_out  = amag[RootW];
  assign root_out  = root[RootW];

endmodule

>>> rtl/dsi_div.sv
module dsi_div
  import dsi_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   valid_in,
  input  carry_t                 carry_in,
  input  logic [1:0][RootW-1:0]  amag_in,
  input  logic [RootW-1:0]       len_in,
  output logic                   valid_out,
  output carry_t                 carry_out,
  output logic [RootW-1:0]       len_out,
  output logic [1:0][QuotW-1:0]  quot_out
);

  localparam int RemW = RootW + QFrac + 1;

  logic                  vld [0:QuotW];
  carry_t                cr  [0:QuotW];
  logic [RootW-1:0]      len [0:QuotW];
  logic [1:0][RemW-1:0]  rem [0:QuotW];
  logic [1:0][QuotW-1:0] quo [0:QuotW];

  assign vld[0] = valid_in;
  assign cr[0]  = carry_in;
  assign len[0] = len_in;
  assign quo[0] = '0;
  assign rem[0][0] = RemW'({amag_in[0], {QFrac{1'b0}}});
  assign rem[0][1] = RemW'({amag_in[1], {QFrac{1'b0}}});

  // Restoring divide, one quotient bit per stage for both lanes
  for (genvar i = 0; i < QuotW; i++) begin : g_stage
    localparam int B = QuotW - 1 - i;
    logic [RemW-1:0] dvs;

    assign dvs = RemW'(len[i]) << B;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      cr[i+1]  <= cr[i];
      len[i+1] <= len[i];
      for (int l = 0; l < 2; l++) begin
        if (rem[i][l] >= dvs) begin
          rem[i+1][l] <= rem[i][l] - dvs;
          quo[i+1][l] <= quo[i][l] | (QuotW'(1) << B);
        end else begin
          rem[i+1][l] <= rem[i][l];
          quo[i+1][l] <= quo[i][l];
        end
      end
    end
  end

  assign valid_out = vld[QuotW];
  assign carry_out = cr[QuotW];
  assign len_out   = len[QuotW];
  assign quot_out  = quo[QuotW];

endmodule

>>> rtl/dsi_force.sv
module dsi_force
  import dsi_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   valid_in,
  input  carry_t                 carry_in,
  input  logic [RootW-1:0]       len_in,
  input  logic [1:0][QuotW-1:0]  quot_in,
  input  logic [CfgW-1:0]        rest_length,
  input  logic [CfgW-1:0]        stiffness,
  input  logic [CfgW-1:0]        damping,
  output logic                   valid_out,
  output out_t                   result_out
);

  localparam int KW   = CfgW;                 // k*u magnitude
  localparam int DW   = VelW + CfgW - QFrac;  // damping term magnitude
  localparam int FW   = RootW + CfgW - QFrac; // force magnitude
  localparam int GW   = FW + 2;               // force minus damping, magnitude
  localparam int IW   = GW + 1;               // impulse magnitude
  localparam int SW   = IW + 1;               // signed impulse
  localparam int ExtW = RootW + 1;

  localparam logic signed [SW-1:0] OutMax = SW'(64'sh7FFF_FFFF);
  localparam logic signed [SW-1:0] OutMin = SW'(-64'sh8000_0000);

  // Clip to 32 bits; top bit of the result flags a clip
  function automatic logic [WordW:0] clip32(input logic signed [SW-1:0] v);
    logic [WordW:0] r;
    if (v > OutMax) begin
      r = {1'b1, OutMax[WordW-1:0]};
    end else if (v < OutMin) begin
      r = {1'b1, OutMin[WordW-1:0]};
    end else begin
      r = {1'b0, v[WordW-1:0]};
    end
    return r;
  endfunction

  logic [5:1] vld;
  carry_t     cr [1:4];

  // Stage 1: k*u, damping product, extension
  logic [1:0][KW-1:0]    s1_km;
  logic [1:0][DW-1:0]    s1_dm;
  logic [RootW-1:0]      s1_extm;
  logic                  s1_extneg;
  logic signed [ExtW-1:0] ext;

  assign ext = $signed({1'b0, len_in}) - $signed(ExtW'(rest_length));

  always_ff @(posedge clk) begin
    cr[1]     <= carry_in;
    s1_extneg <= ext[ExtW-1];
    s1_extm   <= ext[ExtW-1] ? RootW'(-ext) : RootW'(ext);
    for (int l = 0; l < 2; l++) begin
      s1_km[l] <= KW'((QuotW'(quot_in[l]) * (QuotW + CfgW)'(stiffness)) >> QFrac);
      s1_dm[l] <= DW'(((VelW + CfgW)'(carry_in.vmag[l]) * (VelW + CfgW)'(damping)) >> QFrac);
    end
  end

  // Stage 2: force = (k*u) * extension, sign set for the endpoint that moves
  logic [1:0][FW-1:0] s2_fm;
  logic [1:0]         s2_fneg;
  logic [1:0][DW-1:0] s2_dm;

  always_ff @(posedge clk) begin
    cr[2] <= cr[1];
    s2_dm <= s1_dm;
    for (int l = 0; l < 2; l++) begin
      s2_fm[l]   <= FW'(((RootW + KW)'(s1_extm) * (RootW + KW)'(s1_km[l])) >> QFrac);
      s2_fneg[l] <= cr[1].dneg[l] ^ s1_extneg ^ (cr[1].second_fixed & ~cr[1].first_fixed);
    end
  end

  // Stage 3: subtract damping, halve when both ends move
  logic [1:0][GW-1:0] s3_gm;
  logic [1:0]         s3_gneg;
  logic signed [GW:0] g [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      g[l] = (s2_fneg[l] ? -$signed((GW + 1)'(s2_fm[l])) : $signed((GW + 1)'(s2_fm[l])))
           - (cr[2].vneg[l] ? -$signed((GW + 1)'(s2_dm[l]))
                            : $signed((GW + 1)'(s2_dm[l])));
    end
  end

  always_ff @(posedge clk) begin
    cr[3] <= cr[2];
    for (int l = 0; l < 2; l++) begin
      s3_gneg[l] <= g[l][GW];
      if (cr[2].first_fixed | cr[2].second_fixed) begin
        s3_gm[l] <= g[l][GW] ? GW'(-g[l]) : GW'(g[l]);
      end else begin
        s3_gm[l] <= (g[l][GW] ? GW'(-g[l]) : GW'(g[l])) >> 1;
      end
    end
  end

  // Stage 4: scale by the time step
  logic [1:0][IW-1:0] s4_im;
  logic [1:0]         s4_ineg;

  always_ff @(posedge clk) begin
    cr[4]   <= cr[3];
    s4_ineg <= s3_gneg;
    for (int l = 0; l < 2; l++) begin
      s4_im[l] <= IW'(((GW + DtW)'(s3_gm[l]) * (GW + DtW)'(cr[3].time_step)) >> QFrac);
    end
  end

  // Stage 5: clip and route to the endpoints
  logic signed [SW-1:0] imp [2];
  logic [WordW:0]       pos_c [2];
  logic [WordW:0]       neg_c [2];
  out_t                 res;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      imp[l]   = s4_ineg[l] ? -$signed(SW'(s4_im[l])) : $signed(SW'(s4_im[l]));
      pos_c[l] = clip32(imp[l]);
      neg_c[l] = clip32(-imp[l]);
    end
    res              = '0;
    res.apply_first  = ~cr[4].first_fixed;
    res.apply_second = ~cr[4].second_fixed;
    res.coincident   = cr[4].coincident;
    if (cr[4].coincident || (cr[4].first_fixed && cr[4].second_fixed)) begin
      res.saturated = 1'b0;
    end else if (cr[4].first_fixed) begin
      res.second_imp_x = pos_c[0][WordW-1:0];
      res.second_imp_y = pos_c[1][WordW-1:0];
      res.saturated    = pos_c[0][WordW] | pos_c[1][WordW];
    end else if (cr[4].second_fixed) begin
      res.first_imp_x = pos_c[0][WordW-1:0];
      res.first_imp_y = pos_c[1][WordW-1:0];
      res.saturated   = pos_c[0][WordW] | pos_c[1][WordW];
    end else begin
      res.second_imp_x = pos_c[0][WordW-1:0];
      res.second_imp_y = pos_c[1][WordW-1:0];
      res.first_imp_x  = neg_c[0][WordW-1:0];
      res.first_imp_y  = neg_c[1][WordW-1:0];
      res.saturated    = pos_c[0][WordW] | pos_c[1][WordW]
                       | neg_c[0][WordW] | neg_c[1][WordW];
    end
  end

  always_ff @(posedge clk) begin
    result_out <= res;
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[4:1], valid_in};
    end
  end

  assign valid_out = vld[5];

endmodule

>>> rtl/damped_spring_impulse.sv
// Channel   Handshake                 Payload
// request   start / busy              req (in_t)
// result    result_valid strobe       result (out_t)
// config    cfg_we                    cfg_index, cfg_data
//
// A request passes three setup stages, a 33-stage square root pipeline, a
// 17-stage divider and five force stages on its way to result_valid.
// One request is taken every cycle; busy stays low.
// Reset clears the valid bits and loads the register defaults.
// The result strobe lasts one cycle and cannot be held off.
module damped_spring_impulse
  import dsi_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_data,
  input  in_t                req,
  output logic               result_valid,
  output out_t               result
);

`include "damped_spring_impulse_macros.svh"

  logic [CfgW-1:0] rest_length;
  logic [CfgW-1:0] stiffness;
  logic [CfgW-1:0] damping;

  // Hold the configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rest_length <= RestLenRst;
      stiffness   <= StiffRst;
      damping     <= DampRst;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_REST:  rest_length <= cfg_data;
        CFG_STIFF: stiffness   <= cfg_data;
        CFG_DAMP:  damping     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Stage A: differences, magnitudes and velocity selection
  logic signed [RootW-1:0] dx, dy;
  logic signed [VelW-1:0]  vx, vy;
  carry_t                  a_carry_next;
  logic                    accept;

  assign accept = start & ~busy;

  always_comb begin
    dx = $signed({req.first_pos_x[WordW-1], req.first_pos_x})
       - $signed({req.second_pos_x[WordW-1], req.second_pos_x});
    dy = $signed({req.first_pos_y[WordW-1], req.first_pos_y})
       - $signed({req.second_pos_y[WordW-1], req.second_pos_y});
    if (req.first_fixed) begin
      vx = VelW'(req.second_vel_x);
      vy = VelW'(req.second_vel_y);
    end else if (req.second_fixed) begin
      vx = VelW'(req.first_vel_x);
      vy = VelW'(req.first_vel_y);
    end else begin
      vx = VelW'(req.second_vel_x) - VelW'(req.first_vel_x);
      vy = VelW'(req.second_vel_y) - VelW'(req.first_vel_y);
    end
    a_carry_next.vmag[0]      = vx[VelW-1] ? VelW'(-vx) : VelW'(vx);
    a_carry_next.vmag[1]      = vy[VelW-1] ? VelW'(-vy) : VelW'(vy);
    a_carry_next.vneg         = {vy[VelW-1], vx[VelW-1]};
    a_carry_next.dneg         = {dy[RootW-1], dx[RootW-1]};
    a_carry_next.first_fixed  = req.first_fixed;
    a_carry_next.second_fixed = req.second_fixed;
    a_carry_next.coincident   = (dx == '0) && (dy == '0);
    a_carry_next.time_step    = req.time_step;
  end

  logic                  a_valid, b_valid, c_valid;
  carry_t                a_carry, b_carry, c_carry;
  logic [1:0][RootW-1:0] a_amag, b_amag, c_amag;
  logic [SumW-1:0]       b_sq_x, b_sq_y, c_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      a_valid <= accept;
      b_valid <= a_valid;
      c_valid <= b_valid;
    end
  end

  // Stages A to C: capture, square, sum
  always_ff @(posedge clk) begin
    a_carry   <= a_carry_next;
    a_amag[0] <= dx[RootW-1] ? RootW'(-dx) : RootW'(dx);
    a_amag[1] <= dy[RootW-1] ? RootW'(-dy) : RootW'(dy);
    b_carry   <= a_carry;
    b_amag    <= a_amag;
    b_sq_x    <= SumW'(a_amag[0]) * SumW'(a_amag[0]);
    b_sq_y    <= SumW'(a_amag[1]) * SumW'(a_amag[1]);
    c_carry   <= b_carry;
    c_amag    <= b_amag;
    c_sum     <= b_sq_x + b_sq_y;
  end

  logic                  r_valid, q_valid;
  carry_t                r_carry, q_carry;
  logic [1:0][RootW-1:0] r_amag;
  logic [RootW-1:0]      r_root, q_len;
  logic [1:0][QuotW-1:0] q_quot;

  dsi_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (c_valid),
    .carry_in  (c_carry),
    .amag_in   (c_amag),
    .sum_in    (c_sum),
    .valid_out (r_valid),
    .carry_out (r_carry),
    .amag_out  (r_amag),
    .root_out  (r_root)
  );

  dsi_div u_div (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (r_valid),
    .carry_in  (r_carry),
    .amag_in   (r_amag),
    .len_in    (r_root),
    .valid_out (q_valid),
    .carry_out (q_carry),
    .len_out   (q_len),
    .quot_out  (q_quot)
  );

  dsi_force u_force (
    .clk         (clk),
    .rst         (rst),
    .valid_in    (q_valid),
    .carry_in    (q_carry),
    .len_in      (q_len),
    .quot_in     (q_quot),
    .rest_length (rest_length),
    .stiffness   (stiffness),
    .damping     (damping),
    .valid_out   (result_valid),
    .result_out  (result)
  );

  `DSI_ASSERT_IMPLY(a_coinc_zero, clk, rst, result_valid && result.coincident,
    result.first_imp_x == '0 && result.second_imp_y == '0 && !result.saturated)
  `DSI_ASSERT_IMPLY(a_static_zero, clk, rst, result_valid && !result.apply_first,
    result.first_imp_x == '0 && result.first_imp_y == '0)
  `DSI_ASSERT_IMPLY(a_opposite, clk, rst,
    result_valid && result.apply_first && result.apply_second && !result.saturated,
    result.first_imp_x == -result.second_imp_x && result.first_imp_y == -result.second_imp_y)

endmodule

>>> tb/sv/damped_spring_impulse_checker.sv
`timescale 1ns / 100ps

module damped_spring_impulse_checker
  import dsi_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_data,
  input  in_t                req,
  input  logic               result_valid,
  input  out_t               result,
  output int                 pending,
  output int                 fail_count
);

  logic [CfgW-1:0] rest_len_q;
  logic [CfgW-1:0] stiff_q;
  logic [CfgW-1:0] damp_q;
  out_t            impulse_queue[$];
  int              mismatch_total = 0;

  function automatic longint unsigned mag64(longint a);
    return (a < 0) ? longint'(0) - a : a;
  endfunction

  // Q16.16 product, truncated toward zero on the magnitude
  function automatic longint qmul(longint a, longint unsigned b);
    longint unsigned m;
    longint unsigned p;
    m = mag64(a);
    p = (m >> 16) * b + (((m & 64'hFFFF) * b) >> 16);
    return (a < 0) ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint qmul_signed(longint a, longint b);
    longint p;
    p = qmul(a, mag64(b));
    return (b < 0) ? -p : p;
  endfunction

  function automatic logic [32:0] root_floor(logic [65:0] s);
    logic [32:0] r;
    logic [32:0] c;
    logic [65:0] sq;
    r = '0;
    for (int b = 32; b >= 0; b--) begin
      c = r | (33'd1 << b);
      sq = {33'd0, c} * {33'd0, c};
      if (sq <= s) r = c;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] clip32(longint v, inout logic sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7FFFFFFF;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // Work out the impulses for one spring request
  function automatic out_t spring_impulse(in_t r);
    out_t o;
    longint dx, dy, ux, uy, ext, fx, fy, gx, gy, hx, hy;
    longint i0x, i0y, i1x, i1y;
    longint unsigned ax, ay, len;
    logic [65:0] sum;
    logic coinc, sat;
    dx = longint'(r.first_pos_x) - longint'(r.second_pos_x);
    dy = longint'(r.first_pos_y) - longint'(r.second_pos_y);
    coinc = (dx == 0) && (dy == 0);
    sat = 1'b0;
    i0x = 0; i0y = 0; i1x = 0; i1y = 0;
    if (!coinc && !(r.first_fixed && r.second_fixed)) begin
      ax = mag64(dx);
      ay = mag64(dy);
      sum = 66'(ax) * 66'(ax) + 66'(ay) * 66'(ay);
      len = root_floor(sum);
      if (len == 0) len = 1;
      ux = longint'((ax << 16) / len);
      uy = longint'((ay << 16) / len);
      if (dx < 0) ux = -ux;
      if (dy < 0) uy = -uy;
      ext = longint'(len) - longint'(rest_len_q);
      fx = qmul_signed(ext, qmul(ux, stiff_q));
      fy = qmul_signed(ext, qmul(uy, stiff_q));
      if (r.first_fixed) begin
        i1x = qmul(fx - qmul(longint'(r.second_vel_x), damp_q), r.time_step);
        i1y = qmul(fy - qmul(longint'(r.second_vel_y), damp_q), r.time_step);
      end else if (r.second_fixed) begin
        i0x = qmul(-fx - qmul(longint'(r.first_vel_x), damp_q), r.time_step);
        i0y = qmul(-fy - qmul(longint'(r.first_vel_y), damp_q), r.time_step);
      end else begin
        gx = fx - qmul(longint'(r.second_vel_x) - longint'(r.first_vel_x), damp_q);
        gy = fy - qmul(longint'(r.second_vel_y) - longint'(r.first_vel_y), damp_q);
        hx = longint'(mag64(gx) >> 1);
        hy = longint'(mag64(gy) >> 1);
        if (gx < 0) hx = -hx;
        if (gy < 0) hy = -hy;
        i1x = qmul(hx, r.time_step);
        i1y = qmul(hy, r.time_step);
        i0x = -i1x;
        i0y = -i1y;
      end
    end
    o.first_imp_x  = clip32(i0x, sat);
    o.first_imp_y  = clip32(i0y, sat);
    o.second_imp_x = clip32(i1x, sat);
    o.second_imp_y = clip32(i1y, sat);
    o.apply_first  = !r.first_fixed;
    o.apply_second = !r.second_fixed;
    o.coincident   = coinc;
    o.saturated    = sat;
    return o;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatch_total++;
  endtask

  assign fail_count = mismatch_total;

  assign pending = impulse_queue.size();

  // Track config, predict on each request, compare each result
  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      rest_len_q <= RestLenRst;
      stiff_q    <= StiffRst;
      damp_q     <= DampRst;
    end else begin
      if (start && !busy) impulse_queue = {impulse_queue, spring_impulse(req)};
      if (cfg_we) begin
        case (cfg_index)
          CFG_REST:  rest_len_q <= cfg_data;
          CFG_STIFF: stiff_q    <= cfg_data;
          CFG_DAMP:  damp_q     <= cfg_data;
          default: ;
        endcase
      end
      if (result_valid) begin
        if (impulse_queue.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = impulse_queue.pop_front();
          if (result.first_imp_x !== want.first_imp_x)
            report_mismatch("first_imp_x", result.first_imp_x, want.first_imp_x);
          if (result.first_imp_y !== want.first_imp_y)
            report_mismatch("first_imp_y", result.first_imp_y, want.first_imp_y);
          if (result.second_imp_x !== want.second_imp_x)
            report_mismatch("second_imp_x", result.second_imp_x, want.second_imp_x);
          if (result.second_imp_y !== want.second_imp_y)
            report_mismatch("second_imp_y", result.second_imp_y, want.second_imp_y);
          if (result.apply_first !== want.apply_first)
            report_mismatch("apply_first", result.apply_first, want.apply_first);
          if (result.apply_second !== want.apply_second)
            report_mismatch("apply_second", result.apply_second, want.apply_second);
          if (result.coincident !== want.coincident)
            report_mismatch("coincident", result.coincident, want.coincident);
          if (result.saturated !== want.saturated)
            report_mismatch("saturated", result.saturated, want.saturated);
        end
      end
    end
  end

endmodule

>>> tb/sv/damped_spring_impulse_tb.sv
`timescale 1ns / 100ps

module damped_spring_impulse_tb;
  import dsi_pkg::*;

  localparam int DrainCycles = 80;
  localparam int CycleLimit  = 300000;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgW-1:0]    cfg_data;
  in_t                req;
  logic               result_valid;
  out_t               result;
  int                 pending;
  int                 fail_count;
  int                 cycle_count = 0;

  damped_spring_impulse uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req(req), .result_valid(result_valid), .result(result)
  );

  damped_spring_impulse_checker checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req(req), .result_valid(result_valid), .result(result),
    .pending(pending), .fail_count(fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("damped_spring_impulse_tb: errors");
      $finish;
    end
  end

  // Present one request and hold it until taken
  task automatic send_request(in_t item);
    req   <= item;
    start <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_cycles(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Write all three registers once the pipe has drained
  task automatic load_spring(logic [CfgW-1:0] rest, logic [CfgW-1:0] stiff,
                             logic [CfgW-1:0] damp);
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= CFG_REST;  cfg_data <= rest;
    @(posedge clk);
    cfg_index <= CFG_STIFF; cfg_data <= stiff;
    @(posedge clk);
    cfg_index <= CFG_DAMP;  cfg_data <= damp;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      default: return $urandom;
    endcase
  endfunction

  // Build one random spring request
  function automatic in_t rand_spring();
    in_t r;
    logic [31:0] spread;
    r.first_pos_x = $urandom;
    r.first_pos_y = $urandom;
    case ($urandom_range(0, 9))
      0: begin
        r.second_pos_x = r.first_pos_x;
        r.second_pos_y = r.first_pos_y;
      end
      1, 2: begin
        r.first_pos_x  = rand_word();
        r.first_pos_y  = rand_word();
        r.second_pos_x = rand_word();
        r.second_pos_y = rand_word();
      end
      default: begin
        spread = 32'd1 << $urandom_range(1, 22);
        r.second_pos_x = r.first_pos_x + ($urandom % spread) - (spread >> 1);
        r.second_pos_y = r.first_pos_y + ($urandom % spread) - (spread >> 1);
      end
    endcase
    r.first_vel_x  = rand_word();
    r.first_vel_y  = rand_word();
    r.second_vel_x = rand_word();
    r.second_vel_y = rand_word();
    r.first_fixed  = ($urandom_range(0, 4) == 0);
    r.second_fixed = ($urandom_range(0, 4) == 0);
    case ($urandom_range(0, 9))
      0: r.time_step = 17'd65536;
      1: r.time_step = DtW'($urandom_range(65537, 131071));
      2: r.time_step = 17'd0;
      default: r.time_step = DtW'($urandom_range(0, 65536));
    endcase
    return r;
  endfunction

  function automatic in_t spring_at(logic [31:0] ax, logic [31:0] ay, logic [31:0] bx,
                                    logic [31:0] by, logic f0, logic f1,
                                    logic [31:0] vel, logic [16:0] dt);
    in_t r;
    r.first_pos_x = ax;  r.first_pos_y = ay;
    r.second_pos_x = bx; r.second_pos_y = by;
    r.first_vel_x = vel; r.first_vel_y = -vel;
    r.second_vel_x = -vel; r.second_vel_y = vel;
    r.first_fixed = f0; r.second_fixed = f1;
    r.time_step = dt;
    return r;
  endfunction

  // Random bursts of requests with random gaps
  task automatic random_phase(int count);
    int sent;
    int burst;
    sent = 0;
    while (sent < count) begin
      burst = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 12);
      for (int i = 0; i < burst && sent < count; i++) begin
        send_request(rand_spring());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 6));
    end
  endtask

  initial begin
    rst = 1'b1; start = 1'b0; cfg_we = 1'b0;
    cfg_index = CFG_REST; cfg_data = '0; req = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: coincidence, each static case, position and step extremes
    send_request(spring_at(0, 0, 0, 0, 0, 0, 32'h10000, 17'd65536));
    send_request(spring_at(5, 7, 5, 7, 1, 1, 0, 17'd65536));
    send_request(spring_at(32'h30000, 0, 0, 0, 0, 0, 32'h8000, 17'd65536));
    send_request(spring_at(32'h30000, 0, 0, 0, 1, 0, 32'h8000, 17'd65536));
    send_request(spring_at(32'h30000, 0, 0, 0, 0, 1, 32'h8000, 17'd65536));
    send_request(spring_at(32'h30000, 0, 0, 0, 1, 1, 32'h8000, 17'd65536));
    send_request(spring_at(0, 32'h8000, 0, 0, 0, 0, 0, 17'd32768));
    send_request(spring_at(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
                           0, 0, 32'h7FFFFFFF, 17'd65536));
    send_request(spring_at(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                           0, 1, 32'h80000000, 17'd131071));
    send_request(spring_at(32'h80000000, 0, 32'h7FFFFFFF, 0, 1, 0, 32'h80000000,
                           17'd65536));
    send_request(spring_at(1, 0, 0, 0, 0, 0, 32'hFFFFFFFF, 17'd1));
    send_request(spring_at(32'h7FFFFFFF, 0, 32'h7FFFFFFF, 1, 0, 0, 0, 17'd0));
    idle_cycles(1);

    random_phase(200);
    load_spring(31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF);
    send_request(spring_at(32'h10000, 0, 0, 0, 0, 0, 32'h7FFFFFFF, 17'd65536));
    send_request(spring_at(32'h7FFFFFFF, 0, 32'h80000000, 0, 1, 0, 32'h80000000,
                           17'd65536));
    random_phase(200);
    load_spring(31'd0, 31'd0, 31'd0);
    random_phase(200);
    load_spring(31'd0, 31'h7FFFFFFF, 31'd0);
    random_phase(200);
    load_spring(CfgW'($urandom), CfgW'($urandom_range(0, 1 << 20)),
                CfgW'($urandom_range(0, 1 << 18)));
    random_phase(250);
    load_spring(CfgW'($urandom_range(0, 1 << 22)), CfgW'($urandom), CfgW'($urandom));
    random_phase(250);

    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("damped_spring_impulse_tb: clean");
    end else begin
      $display("damped_spring_impulse_tb: errors");
    end
    $finish;
  end

endmodule
